/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/tsm_pkg.sv */
`timescale 1ns / 1ps
package tsm_pkg;
	// Parameter defaults.
	localparam int CHANNELS_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;

	// Configuration port.
	localparam int CFG_BITS = 8;
	localparam logic REG_MERGE_MODE     = 1'b0;
	localparam logic REG_CHANNEL_ENABLE = 1'b1;
	localparam logic [1:0] MERGE_MODE_RST = 2'd1;

	// Merge modes.
	localparam logic [1:0] MODE_MUX = 2'd0;
	localparam logic [1:0] MODE_AND = 2'd1;
	localparam logic [1:0] MODE_OR  = 2'd2;

	// Actions of an input item.
	localparam logic [1:0] ACT_PUSH    = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_MERGED   = 3'd0;
	localparam logic [2:0] ST_NONE_DUE = 3'd1;
	localparam logic [2:0] ST_PUSH_OK  = 3'd2;
	localparam logic [2:0] ST_DROPPED  = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_POP_RD,
		S_POP_CMP,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_POP_RD,
		OP_POP_CMP,
		OP_EMIT
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		op_t  op;
		logic in_ready;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_valid;
		logic in_adv;
		logic out_free;
		logic ch_last;
		logic elig;
		logic due;
		logic head_due;
		logic emit_done;
	} sts_t;
endpackage

/* rtl/tsm_if.sv */
`timescale 1ns / 1ps
interface tsm_in_if #(parameter int TIME_BITS = tsm_pkg::TIME_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           action;
	logic [2:0]           channel;
	logic [TIME_BITS-1:0] event_time;
	logic                 event_level;

	modport source(output valid, action, channel, event_time, event_level, input ready);
	modport sink(input valid, action, channel, event_time, event_level, output ready);
endinterface

interface tsm_out_if #(parameter int TIME_BITS = tsm_pkg::TIME_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           status;
	logic [TIME_BITS-1:0] out_time;
	logic                 out_level;
	logic [2:0]           out_channel;
	logic                 more_due;
	logic                 last;

	modport source(output valid, status, out_time, out_level, out_channel, more_due, last,
		input ready);
	modport sink(input valid, status, out_time, out_level, out_channel, more_due, last,
		output ready);
endinterface

/* rtl/timestamped_event_stream_merger.sv */
`timescale 1ns / 1ps
// Channel   Role     Handshake      Payload
// evt_in    sink     valid/ready    action, channel, event_time, event_level
// evt_out   source   valid/ready    status, out_time, out_level, out_channel, more_due, last
// cfg       write    cfg_we         cfg_index, cfg_data
//
// Push, clear and unused actions are accepted in idle, then wait for the result register.
// An advance scans the queue heads with a read and a compare state per channel, then pops
// the due heads with a read and a compare per head, skipping idle channels, then emits the
// fired channels one by one in mux mode; the single read port of the store sets these steps.
// Reset (arst_n, asynchronous) empties all queues and clears the held levels.
// A stalled result register holds new items off at evt_in.ready.
module timestamped_event_stream_merger #(
	parameter int CHANNELS    = tsm_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = tsm_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [tsm_pkg::CFG_BITS-1:0] cfg_data,
	tsm_in_if.sink                       evt_in,
	tsm_out_if.source                    evt_out
);
	import tsm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	tsm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Queues, compare logic and result register.
	tsm_dp #(
		.CHANNELS    (CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.evt_in    (evt_in),
		.evt_out   (evt_out),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

/* rtl/tsm_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  tsm_pkg::sts_t sts,
	output tsm_pkg::cmd_t cmd
);
	import tsm_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sts.in_valid && sts.out_free && sts.in_adv) state_d = S_SCAN_RD;
			end
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				state_d = sts.ch_last ? S_POP_RD : S_SCAN_RD;
			end
			S_POP_RD: begin
				if (!sts.due) state_d = S_EMIT;
				else if (sts.elig) state_d = S_POP_CMP;
				else if (sts.ch_last) state_d = S_EMIT;
			end
			S_POP_CMP: begin
				if (sts.head_due) state_d = S_POP_RD;
				else if (sts.ch_last) state_d = S_EMIT;
				else state_d = S_POP_RD;
			end
			S_EMIT: begin
				if (sts.emit_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.in_ready = (state_q == S_IDLE) && sts.out_free;
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:     if (sts.in_valid && sts.out_free) cmd.op = OP_ACCEPT;
			S_SCAN_RD:  cmd.op = OP_SCAN_RD;
			S_SCAN_CMP: cmd.op = OP_SCAN_CMP;
			S_POP_RD:   cmd.op = OP_POP_RD;
			S_POP_CMP:  cmd.op = OP_POP_CMP;
			S_EMIT:     cmd.op = OP_EMIT;
			default:    cmd.op = OP_NONE;
		endcase
	end

	`ASSERT_NEXT(a_pop_cmp_exit, clk, arst_n, state_q == S_POP_CMP, state_q == S_POP_RD || state_q == S_EMIT)
endmodule

/* rtl/tsm_dp.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tsm_dp #(
	parameter int CHANNELS    = tsm_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = tsm_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [tsm_pkg::CFG_BITS-1:0]   cfg_data,
	tsm_in_if.sink                         evt_in,
	tsm_out_if.source                      evt_out,
	input  tsm_pkg::cmd_t                  cmd,
	output tsm_pkg::sts_t                  sts
);
	import tsm_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(CHANNELS * QUEUE_DEPTH);

	// Configuration registers.
	logic [1:0]          mode_q;
	logic [CFG_BITS-1:0] en_q;

	// Per-channel queue control.
	logic [PW-1:0] rp_q  [CHANNELS];
	logic [PW-1:0] wp_q  [CHANNELS];
	logic [NW-1:0] cnt_q [CHANNELS];
	logic [CHANNELS-1:0] held_q;
	logic [CHANNELS-1:0] fired_q;

	// Advance working registers.
	logic [CW-1:0]        ch_q;
	logic                 found_q;
	logic [TIME_BITS-1:0] cur_q;
	logic                 nfound_q;
	logic [TIME_BITS-1:0] nxt_q;
	logic [TIME_BITS-1:0] limit_q;

	// Event store and its registered read port.
	logic [TIME_BITS:0] mem_q [CHANNELS * QUEUE_DEPTH];
	logic [TIME_BITS:0] rd_q;

	// Result register.
	logic                 out_valid_q;
	logic [2:0]           out_status_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic                 out_level_q;
	logic [2:0]           out_channel_q;
	logic                 out_more_q;
	logic                 out_last_q;

	logic [CHANNELS-1:0]  en_ch;
	logic                 elig, ch_last, head_due, due, more, out_free;
	logic                 fired_above, acc, in_ch_ok, push_ok, out_load;
	logic [2:0]           in_status;
	logic [CW-1:0]        ch_nx, in_sel;
	logic [TIME_BITS-1:0] rd_time;
	logic [AW-1:0]        rd_addr, wr_addr;

	// Only the channels covered by the enable register can be enabled.
	genvar gi;
	generate
		for (gi = 0; gi < CHANNELS; gi++) begin : g_en
			if (gi < CFG_BITS) begin : g_on
				assign en_ch[gi] = en_q[gi];
			end else begin : g_off
				assign en_ch[gi] = 1'b0;
			end
		end
	endgenerate

	// Decode of the current channel and the read data.
	assign rd_time     = rd_q[TIME_BITS-1:0];
	assign elig        = en_ch[ch_q] && (cnt_q[ch_q] != '0);
	assign ch_last     = (ch_q == CW'(CHANNELS - 1));
	assign ch_nx       = ch_last ? '0 : ch_q + 1'b1;
	assign head_due    = (rd_time <= cur_q);
	assign due         = found_q && (cur_q <= limit_q);
	assign more        = nfound_q && (nxt_q <= limit_q);
	assign out_free    = !out_valid_q || evt_out.ready;
	assign fired_above = (((fired_q >> ch_q) >> 1) != '0);
	assign rd_addr     = AW'(ch_q * QUEUE_DEPTH) + AW'(rp_q[ch_q]);

	// Combined level of the logic modes; an unused mode reads as low.
	always_comb begin
		case (mode_q)
			MODE_AND: acc = &(held_q | ~en_ch);
			MODE_OR:  acc = |(held_q & en_ch);
			default:  acc = 1'b0;
		endcase
	end

	// Push target check.
	assign in_ch_ok = (32'(evt_in.channel) < CHANNELS);
	assign in_sel   = CW'(evt_in.channel);
	assign push_ok  = in_ch_ok && (cnt_q[in_sel] < NW'(QUEUE_DEPTH));
	assign wr_addr  = AW'(in_sel * QUEUE_DEPTH) + AW'(wp_q[in_sel]);

	// Status of the single result of a push, a clear or an unused action.
	always_comb begin
		case (evt_in.action)
			ACT_PUSH:  in_status = push_ok ? ST_PUSH_OK : ST_DROPPED;
			ACT_CLEAR: in_status = ST_CLEARED;
			default:   in_status = ST_NONE_DUE;
		endcase
	end

	// A new result enters the result register.
	assign out_load = (cmd.op == OP_ACCEPT && evt_in.action != ACT_ADVANCE) ||
		(cmd.op == OP_EMIT && out_free && (!due || mode_q != MODE_MUX || fired_q[ch_q]));

	// Event store write and read.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT && evt_in.action == ACT_PUSH && push_ok) begin
			mem_q[wr_addr] <= {evt_in.event_level, evt_in.event_time};
		end
		rd_q <= mem_q[rd_addr];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MERGE_MODE_RST;
			en_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MERGE_MODE) mode_q <= cfg_data[1:0];
			else en_q <= cfg_data;
		end
	end

	// Result valid: set on a load, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (evt_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Queue control, advance work and the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rp_q[i]  <= '0;
				wp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
			held_q        <= '0;
			fired_q       <= '0;
			ch_q          <= '0;
			found_q       <= 1'b0;
			cur_q         <= '0;
			nfound_q      <= 1'b0;
			nxt_q         <= '0;
			limit_q       <= '0;
			out_status_q  <= ST_NONE_DUE;
			out_time_q    <= '0;
			out_level_q   <= 1'b0;
			out_channel_q <= '0;
			out_more_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ACCEPT: begin
					found_q  <= 1'b0;
					nfound_q <= 1'b0;
					fired_q  <= '0;
					ch_q     <= '0;
					limit_q  <= evt_in.event_time;
					if (evt_in.action != ACT_ADVANCE) begin
						out_time_q    <= '0;
						out_level_q   <= 1'b0;
						out_channel_q <= '0;
						out_more_q    <= 1'b0;
						out_last_q    <= 1'b1;
						out_status_q  <= in_status;
					end
					if (evt_in.action == ACT_PUSH) begin
						if (push_ok) begin
							wp_q[in_sel]  <= (wp_q[in_sel] == PW'(QUEUE_DEPTH - 1)) ?
								'0 : wp_q[in_sel] + 1'b1;
							cnt_q[in_sel] <= cnt_q[in_sel] + 1'b1;
						end
					end else if (evt_in.action == ACT_CLEAR) begin
						for (int i = 0; i < CHANNELS; i++) begin
							rp_q[i]  <= '0;
							wp_q[i]  <= '0;
							cnt_q[i] <= '0;
						end
						held_q <= '0;
					end
				end
				OP_SCAN_CMP: begin
					if (elig && (!found_q || rd_time < cur_q)) begin
						cur_q   <= rd_time;
						found_q <= 1'b1;
					end
					ch_q <= ch_nx;
				end
				OP_POP_RD: begin
					if (due && !elig) ch_q <= ch_nx;
				end
				OP_POP_CMP: begin
					if (head_due) begin
						held_q[ch_q]  <= rd_q[TIME_BITS];
						fired_q[ch_q] <= 1'b1;
						rp_q[ch_q]    <= (rp_q[ch_q] == PW'(QUEUE_DEPTH - 1)) ?
							'0 : rp_q[ch_q] + 1'b1;
						cnt_q[ch_q]   <= cnt_q[ch_q] - 1'b1;
					end else begin
						// The head that stopped the pops is this channel's new head.
						if (!nfound_q || rd_time < nxt_q) begin
							nxt_q    <= rd_time;
							nfound_q <= 1'b1;
						end
						ch_q <= ch_nx;
					end
				end
				OP_EMIT: begin
					if (!due) begin
						if (out_free) begin
							out_status_q  <= ST_NONE_DUE;
							out_time_q    <= '0;
							out_level_q   <= 1'b0;
							out_channel_q <= '0;
							out_more_q    <= 1'b0;
							out_last_q    <= 1'b1;
						end
					end else if (mode_q == MODE_MUX) begin
						if (!fired_q[ch_q]) begin
							ch_q <= ch_nx;
						end else if (out_free) begin
							out_status_q  <= ST_MERGED;
							out_time_q    <= cur_q;
							out_level_q   <= held_q[ch_q];
							out_channel_q <= 3'(ch_q);
							out_more_q    <= more;
							out_last_q    <= !fired_above;
							ch_q          <= ch_nx;
						end
					end else if (out_free) begin
						out_status_q  <= ST_MERGED;
						out_time_q    <= cur_q;
						out_level_q   <= acc;
						out_channel_q <= '0;
						out_more_q    <= more;
						out_last_q    <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Status to the controller.
	always_comb begin
		sts.in_valid  = evt_in.valid;
		sts.in_adv    = (evt_in.action == ACT_ADVANCE);
		sts.out_free  = out_free;
		sts.ch_last   = ch_last;
		sts.elig      = elig;
		sts.due       = due;
		sts.head_due  = head_due;
		sts.emit_done = out_free && (!due || mode_q != MODE_MUX ||
			(fired_q[ch_q] && !fired_above));
	end

	// Ports.
	assign evt_in.ready        = cmd.in_ready;
	assign evt_out.valid       = out_valid_q;
	assign evt_out.status      = out_status_q;
	assign evt_out.out_time    = out_time_q;
	assign evt_out.out_level   = out_level_q;
	assign evt_out.out_channel = out_channel_q;
	assign evt_out.more_due    = out_more_q;
	assign evt_out.last        = out_last_q;

	`ASSERT_IMPL(a_accept_out_free, clk, arst_n, evt_in.valid && evt_in.ready, out_free)
	`ASSERT_IMPL(a_merged_due, clk, arst_n, out_valid_q && out_status_q == ST_MERGED, due)
endmodule
